// ===== rtl/red_pkg.sv =====
`default_nettype none
package red_pkg;

  localparam int unsigned MaxQueueDefault = 4096;
  localparam int unsigned FillW = 13;
  localparam logic [FillW-1:0] FillLimit = 13'd8191;

  localparam logic [12:0] MinThrReset = 13'd20;
  localparam logic [12:0] MaxThrReset = 13'd80;
  localparam logic [15:0] WeightReset = 16'd131;
  localparam logic [15:0] MaxProbReset = 16'd6554;
  localparam logic [12:0] CapReset = 13'd100;

  localparam logic [2:0] RegMinThr = 3'd0;
  localparam logic [2:0] RegMaxThr = 3'd1;
  localparam logic [2:0] RegWeight = 3'd2;
  localparam logic [2:0] RegMaxProb = 3'd3;
  localparam logic [2:0] RegCap = 3'd4;

  localparam logic [1:0] VerdictEnq = 2'd0;
  localparam logic [1:0] VerdictEarly = 2'd1;
  localparam logic [1:0] VerdictForced = 2'd2;
  localparam logic [1:0] VerdictFull = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_MUL,
    ST_AVG_SUM,
    ST_CLASSIFY,
    ST_PB_MUL,
    ST_DIV,
    ST_CP_MUL,
    ST_TEST_MUL,
    ST_DECIDE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic avg_mul;
    logic avg_sum;
    logic classify;
    logic pb_mul;
    logic div_step;
    logic cp_mul;
    logic test_mul;
    logic decide;
  } red_cmd_t;

  typedef struct packed {
    logic early;
    logic div_done;
  } red_sts_t;

endpackage
`default_nettype wire

// ===== rtl/red_ctrl.sv =====
`default_nettype none
module red_ctrl
  import red_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  wire      out_stall,
  input  red_sts_t sts,
  output red_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_AVG_MUL;
        end
      end
      ST_AVG_MUL: begin
        cmd.avg_mul = 1'b1;
        state_nxt = ST_AVG_SUM;
      end
      ST_AVG_SUM: begin
        cmd.avg_sum = 1'b1;
        state_nxt = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt = sts.early ? ST_PB_MUL : ST_DECIDE;
      end
      ST_PB_MUL: begin
        cmd.pb_mul = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_CP_MUL;
      end
      ST_CP_MUL: begin
        cmd.cp_mul = 1'b1;
        state_nxt = ST_TEST_MUL;
      end
      ST_TEST_MUL: begin
        cmd.test_mul = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/red_dpath.sv =====
`default_nettype none
module red_dpath
  import red_pkg::*;
#(
  parameter int unsigned MAX_QUEUE = MaxQueueDefault
) (
  input  wire         clk,
  input  wire         rst_n,
  input  red_cmd_t    cmd,
  output red_sts_t    sts,
  input  wire  [15:0] in_packet_size,
  input  wire  [15:0] in_random_fraction,
  input  wire  [12:0] min_thr,
  input  wire  [12:0] max_thr,
  input  wire  [15:0] weight,
  input  wire  [15:0] max_prob,
  input  wire  [12:0] capacity,
  output logic [1:0]  out_verdict,
  output logic [31:0] out_avg_length,
  output logic [12:0] out_occupancy,
  output logic [31:0] out_drops_total,
  output logic [15:0] out_size_echo
);

  // Queue limit is the smallest of capacity, MAX_QUEUE and the fill range.
  localparam int unsigned LimPar =
      (MAX_QUEUE > 32'(FillLimit)) ? 32'(FillLimit) : MAX_QUEUE;
  localparam logic [FillW-1:0] LimC = FillW'(LimPar);

  logic [31:0] avg_r;
  logic [12:0] fill_r;
  logic [15:0] since_r;
  logic [31:0] tally_r;

  logic [15:0] size_r, rnd_r;
  logic [48:0] prod_a_r;  // (65536-w)*avg
  logic [48:0] prod_b_r;  // w*(fill<<20)
  logic        early_r, forced_r;
  logic [32:0] num_diff_r;  // avg - min<<20
  logic [32:0] den_r;       // (max-min)<<20
  logic [48:0] rem_r;
  logic [48:0] dividend_r;  // max_prob*(avg-min)
  logic [15:0] pb_r;
  logic [5:0]  div_cnt_r;
  logic [31:0] cp_r;
  logic        cp_big_r;
  logic [32:0] test_r;
  logic [1:0]  verdict_r;

  logic [49:0] avg_sum;
  logic [32:0] min_fx, max_fx;
  logic [49:0] rem_sh;
  logic [12:0] limit;
  logic        drop;
  logic        early_now;

  assign min_fx = {min_thr, 20'd0};
  assign max_fx = {max_thr, 20'd0};
  assign avg_sum = {1'b0, prod_a_r} + {1'b0, prod_b_r};
  assign limit = (capacity < LimC) ? capacity : LimC;
  assign rem_sh = {rem_r, dividend_r[48]};
  assign early_now = ({1'b0, avg_r} >= min_fx) && ({1'b0, avg_r} < max_fx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size_r <= in_packet_size;
      rnd_r <= in_random_fraction;
    end
    if (cmd.avg_mul) begin
      prod_a_r <= 49'(17'd65536 - {1'b0, weight}) * 49'(avg_r);
      prod_b_r <= 49'(weight) * 49'({fill_r, 20'd0});
    end
    if (cmd.classify) begin
      num_diff_r <= {1'b0, avg_r} - min_fx;
      den_r <= max_fx - min_fx;
    end
    if (cmd.pb_mul) begin
      dividend_r <= 49'(max_prob) * 49'(num_diff_r);
      rem_r <= '0;
      div_cnt_r <= 6'd0;
    end else if (cmd.div_step) begin
      // Restoring division, one quotient bit per cycle.
      if (rem_sh >= {17'd0, den_r}) begin
        rem_r <= 49'(rem_sh - {17'd0, den_r});
        dividend_r <= {dividend_r[47:0], 1'b1};
      end else begin
        rem_r <= rem_sh[48:0];
        dividend_r <= {dividend_r[47:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r + 6'd1;
    end
    if (cmd.cp_mul) begin
      pb_r <= dividend_r[15:0];
      cp_r <= since_r * dividend_r[15:0];
    end
    if (cmd.test_mul) begin
      cp_big_r <= cp_r >= 32'd65536;
      test_r <= 33'(rnd_r) * 33'(17'd65536 - {1'b0, cp_r[16:0]});
    end
  end

  assign sts = '{early: early_now, div_done: (div_cnt_r == 6'd48)};

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      early_r <= early_now;
      forced_r <= ({1'b0, avg_r} >= min_fx) && ({1'b0, avg_r} >= max_fx);
    end
  end

  always_comb begin
    drop = forced_r;
    if (early_r) drop = cp_big_r || (test_r < {1'b0, pb_r, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
      fill_r <= '0;
      since_r <= '0;
      tally_r <= '0;
      verdict_r <= VerdictEnq;
    end else begin
      if (cmd.avg_sum) begin
        if (fill_r == '0) avg_r <= '0;
        else if (avg_sum[49:48] != 2'd0) avg_r <= '1;
        else avg_r <= avg_sum[47:16];
      end
      if (cmd.decide) begin
        if (drop) begin
          verdict_r <= early_r ? VerdictEarly : VerdictForced;
          if (tally_r != '1) tally_r <= tally_r + 32'd1;
          if (early_r && since_r != '1) since_r <= since_r + 16'd1;
        end else if (fill_r >= limit) begin
          verdict_r <= VerdictFull;
          if (tally_r != '1) tally_r <= tally_r + 32'd1;
          if (early_r && since_r != '1) since_r <= since_r + 16'd1;
        end else begin
          verdict_r <= VerdictEnq;
          fill_r <= fill_r + 13'd1;
          since_r <= '0;
        end
      end
    end
  end

  assign out_verdict = verdict_r;
  assign out_avg_length = avg_r;
  assign out_occupancy = fill_r;
  assign out_drops_total = tally_r;
  assign out_size_echo = size_r;

endmodule
`default_nettype wire

// ===== rtl/random_early_detection_dropper.sv =====
`default_nettype none
// Random early detection dropper: one verdict per arriving packet. An item is
// taken only when the block is idle, which holds it until its result is accepted.
// When the packet's average lies inside the early region, a 49-step restoring
// divider computes the base drop probability on the way; a result waits while
// out_stall is high. The user must write registers over the APB-style port only
// while no item is in flight; the block itself does not enforce this.
module random_early_detection_dropper
  import red_pkg::*;
#(
  parameter int unsigned MAX_QUEUE = MaxQueueDefault
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [4:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [15:0] in_packet_size,
  input  wire  [15:0] in_random_fraction,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_verdict,
  output logic [31:0] out_avg_length,
  output logic [12:0] out_occupancy,
  output logic [31:0] out_drops_total,
  output logic [15:0] out_size_echo
);

  logic [12:0] min_r, max_r, cap_r;
  logic [15:0] weight_r, prob_r;
  logic [2:0]  idx;
  red_cmd_t cmd;
  red_sts_t sts;

  assign idx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MinThrReset;
      max_r <= MaxThrReset;
      weight_r <= WeightReset;
      prob_r <= MaxProbReset;
      cap_r <= CapReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        RegMinThr: min_r <= cfg_pwdata[12:0];
        RegMaxThr: max_r <= cfg_pwdata[12:0];
        RegWeight: weight_r <= cfg_pwdata[15:0];
        RegMaxProb: prob_r <= cfg_pwdata[15:0];
        RegCap: cap_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegMinThr: cfg_prdata = {19'd0, min_r};
      RegMaxThr: cfg_prdata = {19'd0, max_r};
      RegWeight: cfg_prdata = {16'd0, weight_r};
      RegMaxProb: cfg_prdata = {16'd0, prob_r};
      RegCap: cfg_prdata = {19'd0, cap_r};
      default: cfg_prdata = '0;
    endcase
  end

  red_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  red_dpath #(.MAX_QUEUE(MAX_QUEUE)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_packet_size(in_packet_size), .in_random_fraction(in_random_fraction),
    .min_thr(min_r), .max_thr(max_r), .weight(weight_r), .max_prob(prob_r),
    .capacity(cap_r), .out_verdict(out_verdict), .out_avg_length(out_avg_length),
    .out_occupancy(out_occupancy), .out_drops_total(out_drops_total),
    .out_size_echo(out_size_echo)
  );

endmodule
`default_nettype wire

// ===== rtl/red_checker.sv =====
`default_nettype none
module red_checker
  import red_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_verdict,
  input wire [31:0] out_drops_total,
  input wire [12:0] out_occupancy
);

  // One item in flight: no input is taken while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // A result appears only after an accepted item.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");

  // An enqueued item never shows an empty queue.
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VerdictEnq) |-> out_occupancy != 13'd0)
    else $error("enqueue with zero occupancy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_verdict) &&
      $stable(out_drops_total) && $stable(out_occupancy)))
    else $error("stalled result changed");

endmodule

bind random_early_detection_dropper red_checker u_red_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_verdict(out_verdict),
  .out_drops_total(out_drops_total), .out_occupancy(out_occupancy)
);
`default_nettype wire
